>>> rtl/stk_pkg.sv
// shared types and constants for the sorted top-k table
`timescale 1ns / 1ps
`default_nettype none
package stk_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_W       = 5;
  localparam int SCORE_W     = 32;
  localparam int TAG_W       = 16;
  localparam int POS_W       = 4;
  localparam int COUNT_W     = 5;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 56;
  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(10);

  typedef enum logic {
    REQ_ADD    = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_ADDED         = 2'd0,
    ST_REJECTED      = 2'd1,
    ST_REMOVED       = 2'd2,
    ST_OUT_OF_BOUNDS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    op_t                       op;
    logic signed [SCORE_W-1:0] new_score;
    logic [TAG_W-1:0]          new_tag;
    logic [CNT_W-1:0]          held;
    logic                      open;
    logic [POS_W-1:0]          pos;
  } ctrl_t;

endpackage
`default_nettype wire

>>> rtl/stk_cell.sv
// one table slot: holds an entry and shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none
module stk_cell import stk_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] index,
  input  ctrl_t            ctrl,
  input  entry_t           left_entry,
  input  logic             left_ins,
  input  entry_t           right_entry,
  output entry_t           entry,
  output logic             ins
);

  entry_t           entry_next;
  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] limit;
  logic             valid;
  logic             gt;

  assign idx_ext = CNT_W'(index);
  assign valid   = idx_ext < ctrl.held;
  assign gt      = valid && (ctrl.new_score > entry.score);
  // new entry belongs here or earlier; open slot counts when not full
  assign ins     = gt || (ctrl.open && (idx_ext == ctrl.held));
  // last slot that takes part in the shift; the tail is dropped when full
  assign limit   = ctrl.open ? ctrl.held : ctrl.held - CNT_W'(1);

  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      OP_ADD: begin
        if (ins && !left_ins) begin
          entry_next.score = ctrl.new_score;
          entry_next.tag   = ctrl.new_tag;
        end else if (left_ins && (idx_ext <= limit)) begin
          entry_next = left_entry;
        end
      end
      OP_REMOVE: begin
        if (idx_ext >= CNT_W'(ctrl.pos)) begin
          entry_next = right_entry;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

>>> rtl/sorted_top_k_table.sv
// top level of the sorted top-k table: cell row, count, config and result register
//
//  channel  | signals                          | payload, lowest bit first
//  ---------+----------------------------------+----------------------------------------
//  request  | s_tvalid s_tready s_tdata s_tuser| tdata: entry_score, entry_tag, position
//           |                                  | tuser: req_type
//  result   | m_tvalid m_tready m_tdata m_tuser| tdata: removed_score, removed_tag,
//           |                                  |        entry_count; tuser: status
//  config   | cfg_valid cfg_ready cfg_data     | entries_in_use
//
// one item per cycle unless a result stalls; the result is registered on acceptance
// every cell compares its stored score with the new one and all shift in the same cycle
// the single output register sets the pace: a new item is taken when it is empty or drained
// rst clears the count and the result valid flag and sets entries_in_use to 10
// a stalled result holds the request side; config is always ready
`timescale 1ns / 1ps
`default_nettype none
module sorted_top_k_table import stk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // request
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // entry_score[31:0], entry_tag[47:32], position[51:48]
  input  logic                  s_tuser,   // req_type[0]
  // result
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // removed_score[31:0], removed_tag[47:32],
                                           // entry_count[52:48]
  output logic [1:0]            m_tuser,   // status[1:0]
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data   // entries_in_use[4:0]
);

  // request fields
  logic signed [SCORE_W-1:0] entry_score;
  logic [TAG_W-1:0]          entry_tag;
  logic [POS_W-1:0]          position;
  req_t                      req_type;

  assign entry_score = s_tdata[SCORE_W-1:0];
  assign entry_tag   = s_tdata[SCORE_W +: TAG_W];
  assign position    = s_tdata[SCORE_W+TAG_W +: POS_W];
  assign req_type    = req_t'(s_tuser);

  // registers
  logic [CFG_W-1:0] entries_in_use;
  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] held_next;

  logic             accept;
  logic [CFG_W-1:0] cap;
  logic             open;
  logic             add_ok;
  logic             in_bounds;
  ctrl_t            ctrl;
  status_t          status_next;
  entry_t           removed_next;

  entry_t cells [TABLE_DEPTH];
  logic   ins   [TABLE_DEPTH];

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  // capacity saturates at the table depth
  assign cap  = (entries_in_use < CFG_W'(TABLE_DEPTH)) ? entries_in_use : CFG_W'(TABLE_DEPTH);
  // room for one more; a lowered capacity keeps the table full
  assign open = CNT_W'(held) < CNT_W'(cap);

  // scores are descending, so any cell claiming the insert means the tail loses
  always_comb begin
    add_ok = open;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      add_ok = add_ok || ins[i];
    end
  end

  assign in_bounds = CNT_W'(position) < held;

  always_comb begin
    ctrl.new_score = entry_score;
    ctrl.new_tag   = entry_tag;
    ctrl.held      = held;
    ctrl.open      = open;
    ctrl.pos       = position;
    ctrl.op        = OP_HOLD;
    held_next      = held;
    status_next    = ST_ADDED;
    removed_next   = '0;
    if (req_type == REQ_ADD) begin
      if (add_ok) begin
        status_next = ST_ADDED;
        ctrl.op     = accept ? OP_ADD : OP_HOLD;
        if (open) begin
          held_next = held + CNT_W'(1);
        end
      end else begin
        status_next = ST_REJECTED;
      end
    end else begin
      if (in_bounds) begin
        status_next  = ST_REMOVED;
        ctrl.op      = accept ? OP_REMOVE : OP_HOLD;
        removed_next = cells[position[IDX_W-1:0]];
        held_next    = held - CNT_W'(1);
      end else begin
        status_next = ST_OUT_OF_BOUNDS;
      end
    end
  end

  // row of cells; each sees its left and right neighbor, zero at the ends
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_i;
    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_i = 1'b0;
    end else begin : g_mid
      assign left_e = cells[i-1];
      assign left_i = ins[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cells[i+1];
    end
    stk_cell u_cell (
      .clk         (clk),
      .index       (IDX_W'(i)),
      .ctrl        (ctrl),
      .left_entry  (left_e),
      .left_ins    (left_i),
      .right_entry (right_e),
      .entry       (cells[i]),
      .ins         (ins[i])
    );
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entries_in_use <= cfg_data;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (accept) begin
      held <= held_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser <= status_next;
      m_tdata <= {{(OUT_DATA_W - SCORE_W - TAG_W - COUNT_W){1'b0}},
                  COUNT_W'(held_next), removed_next.tag, removed_next.score};
    end
  end

endmodule
`default_nettype wire

>>> rtl/stk_checker.sv
// port-level checks for the sorted top-k table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module stk_checker import stk_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]            m_tuser
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // each accepted item shows its result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("no result after accepted item");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // only a remove returns entry fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_REMOVED)) |-> (m_tdata[SCORE_W+TAG_W-1:0] == '0))
    else $error("removed fields nonzero");

  // count never exceeds the table depth
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[SCORE_W+TAG_W +: COUNT_W] <= COUNT_W'(TABLE_DEPTH)))
    else $error("entry count beyond table depth");

endmodule

bind sorted_top_k_table stk_checker u_stk_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

>>> tb/tb_sorted_top_k_table.sv
// self-checking testbench for the sorted top-k table: scoreboard against a table model
`timescale 1ns / 1ps
module tb_sorted_top_k_table;
  import stk_pkg::*;

  // one request item as the sender sees it
  typedef struct {
    req_t                      kind;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
    logic [POS_W-1:0]          pos;
  } table_req_t;

  // one result item as the table should answer
  typedef struct {
    status_t                   status;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
    logic [COUNT_W-1:0]        count;
  } table_resp_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data = '0;

  // table model state
  logic signed [SCORE_W-1:0] tab_score [TABLE_DEPTH];
  logic [TAG_W-1:0]          tab_tag   [TABLE_DEPTH];
  int                        tab_held;
  logic [CFG_W-1:0]          tab_cap;

  table_req_t  pending_reqs[$];
  table_resp_t expected_resps[$];

  int fail_count = 0;
  bit idle_on = 1'b1;      // random idle bursts allowed
  bit req_taken = 1'b0;    // request item accepted at the last rising edge
  int send_gap = 0;
  int recv_stall = 0;
  int long_hold_req = 0;   // bumped by the sequencer to ask for a long receiver hold-off
  int long_hold_done = 0;

  sorted_top_k_table dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // model of one request: sorted insert after equal scores, drop or reject when full,
  // remove with gap closing, out-of-bounds remove leaves the table alone
  task automatic predict_table_op(input table_req_t r);
    int          cap_now;
    int          slot;
    int          j;
    table_resp_t e;
    e.status = ST_ADDED;
    e.score  = '0;
    e.tag    = '0;
    if (r.kind == REQ_ADD) begin
      cap_now = (tab_cap < TABLE_DEPTH) ? int'(tab_cap) : TABLE_DEPTH;
      slot = -1;
      if (tab_held >= cap_now) begin
        // full (or capacity lowered below the count): replace the last entry only if beaten
        if (tab_held == 0 || !(r.score > tab_score[tab_held-1])) begin
          e.status = ST_REJECTED;
        end else begin
          slot = tab_held - 1;
        end
      end else begin
        slot = tab_held;
        tab_held++;
      end
      if (slot >= 0) begin
        while (slot > 0 && r.score > tab_score[slot-1]) begin
          tab_score[slot] = tab_score[slot-1];
          tab_tag[slot]   = tab_tag[slot-1];
          slot--;
        end
        tab_score[slot] = r.score;
        tab_tag[slot]   = r.tag;
      end
    end else if (int'(r.pos) >= tab_held) begin
      e.status = ST_OUT_OF_BOUNDS;
    end else begin
      e.status = ST_REMOVED;
      e.score  = tab_score[r.pos];
      e.tag    = tab_tag[r.pos];
      for (j = int'(r.pos) + 1; j < tab_held; j++) begin
        tab_score[j-1] = tab_score[j];
        tab_tag[j-1]   = tab_tag[j];
      end
      tab_held--;
    end
    e.count = COUNT_W'(tab_held);
    expected_resps.push_back(e);
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  function automatic table_req_t add_req(input logic [31:0] score, input logic [15:0] tag);
    table_req_t r;
    r.kind  = REQ_ADD;
    r.score = score;
    r.tag   = tag;
    r.pos   = 4'($urandom);
    return r;
  endfunction

  function automatic table_req_t remove_req(input logic [3:0] pos);
    table_req_t r;
    r.kind  = REQ_REMOVE;
    r.score = $urandom;
    r.tag   = 16'($urandom);
    r.pos   = pos;
    return r;
  endfunction

  // random request; scores cluster on a few small values so that ties are common
  function automatic table_req_t rand_req(input int remove_pct);
    table_req_t r;
    logic [31:0] score;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: score = 32'(int'($urandom_range(0, 8)) - 4);
      5:             score = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default:       score = $urandom;
    endcase
    r = add_req(score, 16'($urandom));
    if (int'($urandom_range(0, 99)) < remove_pct) begin
      r.kind = REQ_REMOVE;
      r.pos  = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom);
    end
    return r;
  endfunction

  // sender: a new item only once the last one was taken
  always @(negedge clk) begin
    table_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        send_gap = $urandom_range(1, 14) - 1;
        s_tvalid <= 1'b0;
      end else begin
        nxt = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= nxt.kind;
        s_tdata  <= {4'b0, nxt.pos, nxt.tag, nxt.score};
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  always @(negedge clk) begin
    if (long_hold_done < long_hold_req) begin
      long_hold_done++;
      recv_stall = 300;
    end
    if (recv_stall > 0) begin
      recv_stall--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      recv_stall = $urandom_range(1, 14) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: results checked in order, accepted requests fed to the model
  always @(posedge clk) begin
    table_req_t  r;
    table_resp_t e;
    req_taken = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_resps.size() == 0) begin
          $error("result item with nothing expected: status %0d", m_tuser);
          fail_count++;
        end else begin
          e = expected_resps.pop_front();
          check_field("status", 32'(e.status), 32'(m_tuser));
          check_field("removed_score", e.score, m_tdata[31:0]);
          check_field("removed_tag", 32'(e.tag), 32'(m_tdata[47:32]));
          check_field("entry_count", 32'(e.count), 32'(m_tdata[52:48]));
        end
      end
      if (s_tvalid && s_tready) begin
        req_taken = 1'b1;
        r.kind  = req_t'(s_tuser);
        r.score = s_tdata[31:0];
        r.tag   = s_tdata[47:32];
        r.pos   = s_tdata[51:48];
        predict_table_op(r);
      end
    end
  end

  // block until every queued item went in and every result came out
  task automatic wait_drain();
    do begin
      @(negedge clk);
      #1;
    end while (pending_reqs.size() != 0 || s_tvalid || expected_resps.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tab_cap = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sequencer
  initial begin
    logic [CFG_W-1:0] caps[10];
    int               remove_pcts[10];
    int               p;
    int               k;
    caps        = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd2, 5'd16, 5'd12, 5'd4, 5'd10};
    remove_pcts = '{35, 40, 75, 40, 45, 50, 30, 45, 50, 45};
    tab_held = 0;
    tab_cap  = CAP_RESET;
    for (k = 0; k < TABLE_DEPTH; k++) begin
      tab_score[k] = '0;
      tab_tag[k]   = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset capacity of ten
    pending_reqs.push_back(add_req(32'h7FFF_FFFF, 16'hFFFF));
    pending_reqs.push_back(add_req(32'h8000_0000, 16'h0000));
    pending_reqs.push_back(add_req(32'h0, 16'h0001));
    pending_reqs.push_back(add_req(32'h0, 16'h0002));        // tie goes after
    pending_reqs.push_back(add_req(32'h7FFF_FFFF, 16'h0003)); // tie at the top
    pending_reqs.push_back(remove_req(4'hF));                 // out of bounds
    pending_reqs.push_back(remove_req(4'h0));
    pending_reqs.push_back(remove_req(4'h3));                 // last entry
    pending_reqs.push_back(add_req(32'd100, 16'h0010));
    pending_reqs.push_back(add_req(32'd50, 16'h0011));
    pending_reqs.push_back(add_req(32'd50, 16'h0012));
    pending_reqs.push_back(add_req(-32'sd7, 16'h0013));
    pending_reqs.push_back(add_req(-32'sd7, 16'h0014));
    pending_reqs.push_back(add_req(32'h8000_0000, 16'h0015));
    pending_reqs.push_back(add_req(32'd1, 16'h0016));         // table now full
    pending_reqs.push_back(add_req(32'h8000_0000, 16'h0017)); // equal to last: rejected
    pending_reqs.push_back(add_req(-32'sd8, 16'h0018));       // drops the last
    pending_reqs.push_back(add_req(-32'sd9, 16'h0019));       // too low
    pending_reqs.push_back(add_req(-32'sd8, 16'h001A));       // equal to last
    pending_reqs.push_back(add_req(32'h7FFF_FFFF, 16'h001B)); // drops the last
    pending_reqs.push_back(remove_req(4'd9));
    pending_reqs.push_back(remove_req(4'd10));                // past the count
    pending_reqs.push_back(add_req(32'h7FFF_FFFF, 16'hAAAA));
    pending_reqs.push_back(remove_req(4'd0));
    wait_drain();

    // random phases over capacity settings, including lowering below the count,
    // zero, and above the table depth
    for (p = 0; p < 10; p++) begin
      write_capacity(caps[p]);
      if (p == 9) idle_on = 1'b0;   // last phase runs at full rate
      for (k = 0; k < 130; k++) pending_reqs.push_back(rand_req(remove_pcts[p]));
      if (p == 0) long_hold_req++;   // result side blocked while requests keep coming
      if (p == 4) begin
        // sender halts midway until the table has answered everything
        wait_drain();
        for (k = 0; k < 30; k++) pending_reqs.push_back(rand_req(remove_pcts[p]));
      end
      wait_drain();
    end

    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_sorted_top_k_table: PASS");
    end else begin
      $display("tb_sorted_top_k_table: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("tb_sorted_top_k_table: FAIL");
    $finish;
  end

endmodule

>>> files.f
rtl/stk_pkg.sv
rtl/stk_cell.sv
rtl/sorted_top_k_table.sv
rtl/stk_checker.sv
tb/tb_sorted_top_k_table.sv
